[rtl/core/page_frame_allocator_top_assert.svh]
// Assertion macros shared by the page frame allocator modules.
// Included by the controller and the datapath; no other dependencies.
`ifndef PAGE_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define PFA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent
`define PFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/pfa_pkg.sv]
// Shared constants, codes and controller/datapath interface types
// for the page frame allocator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

   // Sizing
   localparam int NUM_FRAMES      = 8;
   localparam int NUM_SLOTS       = 5;
   localparam int PAGE_BYTES_LOG2 = 9;

   localparam int FRAME_W   = $clog2(NUM_FRAMES);
   localparam int PAGE_W    = $clog2(NUM_FRAMES);
   localparam int CNT_W     = $clog2(NUM_FRAMES + 1);
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SIZE_W    = 16;
   localparam int PG_W      = SIZE_W + 1 - PAGE_BYTES_LOG2;
   localparam int SUM_W     = (PG_W + 1 > CNT_W) ? PG_W + 1 : CNT_W;
   localparam int MAP_AW    = 1 + SLOT_W + PAGE_W;
   localparam int MAP_DEPTH = 2 ** MAP_AW;

   // Fixed field widths
   localparam int PROC_W     = 3;
   localparam int IDX_OUT_W  = 3;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   // Request kinds
   typedef enum logic {
      REQ_ARRIVE = 1'b0,
      REQ_TERM   = 1'b1
   } pfa_req_type;

   // Result status codes
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NO_FRAMES = 2'd1,
      STAT_BUSY      = 2'd2,
      STAT_EMPTY     = 2'd3
   } pfa_status_type;

   // Result action codes
   typedef enum logic [1:0] {
      ACT_MAP  = 2'd0,
      ACT_FREE = 2'd1,
      ACT_NONE = 2'd2
   } pfa_action_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_NOPAGE,
      ST_MAP,
      ST_FREE_RD,
      ST_FREE_OUT
   } pfa_state_type;

   // Controller -> datapath commands
   typedef struct packed {
      logic           load_req;  // capture accepted request
      logic           start;     // commit slot state, load page counters
      logic           emit_none; // emit one no-page result with code
      pfa_status_type code;
      logic           map_step;  // pop a frame, record it, emit
      logic           read_map;  // read the frame of the current page
      logic           free_step; // push read frame, emit
   } pfa_cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic arrive;     // latched request is an arrival
      logic slot_ok;    // slot number in range
      logic slot_busy;  // slot in range and active
      logic fits;       // arrival pages fit in the free frames
      logic total_zero; // request touches no page
      logic last_item;  // current page is the final one
      logic out_free;   // output register can take a result
   } pfa_sts_type;

endpackage

`default_nettype wire

[rtl/core/pfa_ctrl.sv]
// Request sequencer for the page frame allocator.
// Depends on pfa_pkg and page_frame_allocator_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "page_frame_allocator_top_assert.svh"

module pfa_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  pfa_pkg::pfa_sts_type sts,
   output pfa_pkg::pfa_cmd_type cmd
);

   pfa_pkg::pfa_state_type  state_ff, state_in;
   pfa_pkg::pfa_status_type code_ff, code_in;

   // State and held status code
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfa_pkg::ST_IDLE;
         code_ff  <= pfa_pkg::STAT_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      code_in    = code_ff;
      cmd        = '0;
      cmd.code   = code_ff;
      req_tready = 1'b0;
      case (state_ff)
         pfa_pkg::ST_IDLE: begin
            // no transfer while reset is held
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load_req = 1'b1;
               state_in     = pfa_pkg::ST_DECODE;
            end
         end
         pfa_pkg::ST_DECODE: begin
            state_in = pfa_pkg::ST_NOPAGE;
            if (sts.arrive) begin
               if (!sts.slot_ok || sts.slot_busy) begin
                  code_in = pfa_pkg::STAT_BUSY;
               end else if (!sts.fits) begin
                  code_in = pfa_pkg::STAT_NO_FRAMES;
               end else begin
                  cmd.start = 1'b1;
                  code_in   = pfa_pkg::STAT_OK;
                  if (!sts.total_zero) state_in = pfa_pkg::ST_MAP;
               end
            end else begin
               if (!sts.slot_busy) begin
                  code_in = pfa_pkg::STAT_EMPTY;
               end else begin
                  cmd.start = 1'b1;
                  code_in   = pfa_pkg::STAT_OK;
                  if (!sts.total_zero) state_in = pfa_pkg::ST_FREE_RD;
               end
            end
         end
         pfa_pkg::ST_NOPAGE: begin
            if (sts.out_free) begin
               cmd.emit_none = 1'b1;
               state_in      = pfa_pkg::ST_IDLE;
            end
         end
         pfa_pkg::ST_MAP: begin
            if (sts.out_free) begin
               cmd.map_step = 1'b1;
               if (sts.last_item) state_in = pfa_pkg::ST_IDLE;
            end
         end
         pfa_pkg::ST_FREE_RD: begin
            cmd.read_map = 1'b1;
            state_in     = pfa_pkg::ST_FREE_OUT;
         end
         pfa_pkg::ST_FREE_OUT: begin
            if (sts.out_free) begin
               cmd.free_step = 1'b1;
               state_in = sts.last_item ? pfa_pkg::ST_IDLE : pfa_pkg::ST_FREE_RD;
            end
         end
         default: begin
            state_in = pfa_pkg::ST_IDLE;
         end
      endcase
   end

   // Checks
   `PFA_ASSERT_NEXT(a_accept_decode, clock, reset, req_tvalid && req_tready, state_ff == pfa_pkg::ST_DECODE, "accepted request not decoded")
   `PFA_ASSERT_NEXT(a_last_to_idle, clock, reset, (cmd.map_step || cmd.free_step) && sts.last_item, state_ff == pfa_pkg::ST_IDLE, "sequencer did not finish after last page")
   `PFA_ASSERT_SAME(a_ready_in_idle, clock, reset, req_tready, state_ff == pfa_pkg::ST_IDLE, "request taken outside idle")

endmodule

`default_nettype wire

[rtl/core/pfa_datapath.sv]
// Datapath of the page frame allocator: free ring, slot tables, frame map
// memory, page counters and result register. Depends on pfa_pkg and the
// assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "page_frame_allocator_top_assert.svh"

module pfa_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  [pfa_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire  [0:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [pfa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [1:0]                       rsp_tuser,
   output logic                             rsp_tlast,
   input  pfa_pkg::pfa_cmd_type             cmd,
   output pfa_pkg::pfa_sts_type             sts
);

   localparam int UNIT = 1 << pfa_pkg::PAGE_BYTES_LOG2;
   localparam int FW   = pfa_pkg::FRAME_W;
   localparam int CW   = pfa_pkg::CNT_W;

   // Request fields
   logic [pfa_pkg::PROC_W-1:0] in_proc;
   logic [pfa_pkg::SIZE_W-1:0] in_text, in_data;
   logic [pfa_pkg::SIZE_W:0]   text_sum, data_sum;

   // Latched request
   logic                        arrive_ff;
   logic                        slot_ok_ff;
   logic [pfa_pkg::SLOT_W-1:0]  slot_ff;
   logic [pfa_pkg::PG_W-1:0]    tp_ff, dp_ff;

   // Slot tables
   logic          active_ff   [pfa_pkg::NUM_SLOTS];
   logic [CW-1:0] text_cnt_ff [pfa_pkg::NUM_SLOTS];
   logic [CW-1:0] data_cnt_ff [pfa_pkg::NUM_SLOTS];

   // Free ring
   logic [FW-1:0] ring_ff [pfa_pkg::NUM_FRAMES];
   logic [FW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff;
   logic [CW:0]   tail_sum;
   logic [FW-1:0] tail;
   logic [FW-1:0] head_frame;

   // Page walk
   logic          seg_ff;
   logic [CW-1:0] idx_ff, idx_nx;
   logic [CW-1:0] tcnt_ff, dcnt_ff;
   logic [CW-1:0] tcnt_in, dcnt_in;
   logic          seg_end;

   // Frame map memory
   logic [FW-1:0]              map_mem [pfa_pkg::MAP_DEPTH];
   logic [pfa_pkg::MAP_AW-1:0] map_addr;
   logic [FW-1:0]              rd_ff;

   // Decode terms
   logic                     busy;
   logic [pfa_pkg::SUM_W-1:0] req_sum;

   // Result register
   logic                        out_valid_ff;
   pfa_pkg::pfa_status_type     out_status_ff;
   pfa_pkg::pfa_action_type     out_action_ff;
   logic                        out_seg_ff;
   logic [pfa_pkg::IDX_OUT_W-1:0] out_page_ff, out_frame_ff;
   logic                        out_last_ff;
   logic                        emit;
   logic                        out_free;

   // Unpack and round sizes up to pages
   assign in_proc  = req_tdata[2:0];
   assign in_text  = req_tdata[18:3];
   assign in_data  = req_tdata[34:19];
   assign text_sum = {1'b0, in_text} + (pfa_pkg::SIZE_W+1)'(UNIT - 1);
   assign data_sum = {1'b0, in_data} + (pfa_pkg::SIZE_W+1)'(UNIT - 1);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         arrive_ff  <= (req_tuser[0] == pfa_pkg::REQ_ARRIVE);
         slot_ok_ff <= (int'(in_proc) < pfa_pkg::NUM_SLOTS);
         slot_ff    <= pfa_pkg::SLOT_W'(in_proc);
         tp_ff      <= text_sum[pfa_pkg::SIZE_W:pfa_pkg::PAGE_BYTES_LOG2];
         dp_ff      <= data_sum[pfa_pkg::SIZE_W:pfa_pkg::PAGE_BYTES_LOG2];
      end
   end

   // Decode: slot state, fit check, counts for the walk
   assign busy    = slot_ok_ff && active_ff[slot_ff];
   assign req_sum = pfa_pkg::SUM_W'(tp_ff) + pfa_pkg::SUM_W'(dp_ff);
   assign tcnt_in = arrive_ff ? CW'(tp_ff) : text_cnt_ff[slot_ff];
   assign dcnt_in = arrive_ff ? CW'(dp_ff) : data_cnt_ff[slot_ff];

   // Slot tables
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pfa_pkg::NUM_SLOTS; i++) begin
            active_ff[i]   <= 1'b0;
            text_cnt_ff[i] <= '0;
            data_cnt_ff[i] <= '0;
         end
      end else if (cmd.start) begin
         active_ff[slot_ff]   <= arrive_ff;
         text_cnt_ff[slot_ff] <= arrive_ff ? tcnt_in : '0;
         data_cnt_ff[slot_ff] <= arrive_ff ? dcnt_in : '0;
      end
   end

   // Page walk: text pages, then data pages
   assign idx_nx  = idx_ff + CW'(1);
   assign seg_end = seg_ff ? (idx_nx == dcnt_ff) : (idx_nx == tcnt_ff);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         tcnt_ff <= tcnt_in;
         dcnt_ff <= dcnt_in;
         seg_ff  <= (tcnt_in == '0);
         idx_ff  <= '0;
      end else if (cmd.map_step || cmd.free_step) begin
         if (!seg_ff && seg_end) begin
            seg_ff <= 1'b1;
            idx_ff <= '0;
         end else begin
            idx_ff <= idx_nx;
         end
      end
   end

   // Free ring: pop at head, push at head + count
   assign head_frame = ring_ff[head_ff];
   assign head_in    = (head_ff == FW'(pfa_pkg::NUM_FRAMES - 1)) ? '0 : head_ff + FW'(1);
   assign tail_sum   = (CW+1)'(head_ff) + (CW+1)'(count_ff);
   assign tail       = (tail_sum >= (CW+1)'(pfa_pkg::NUM_FRAMES))
                       ? FW'(tail_sum - (CW+1)'(pfa_pkg::NUM_FRAMES)) : FW'(tail_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pfa_pkg::NUM_FRAMES; i++) begin
            ring_ff[i] <= FW'(i);
         end
         head_ff  <= '0;
         count_ff <= CW'(pfa_pkg::NUM_FRAMES);
      end else if (cmd.map_step) begin
         head_ff  <= head_in;
         count_ff <= count_ff - CW'(1);
      end else if (cmd.free_step && (count_ff < CW'(pfa_pkg::NUM_FRAMES))) begin
         ring_ff[tail] <= rd_ff;
         count_ff      <= count_ff + CW'(1);
      end
   end

   // Frame map memory: written on map, read into a register in the state before each free
   assign map_addr = {seg_ff, slot_ff, idx_ff[pfa_pkg::PAGE_W-1:0]};

   always_ff @(posedge clock) begin
      if (cmd.map_step) begin
         map_mem[map_addr] <= head_frame;
      end
      if (cmd.read_map) begin
         rd_ff <= map_mem[map_addr];
      end
   end

   // Result register
   assign emit     = cmd.emit_none || cmd.map_step || cmd.free_step;
   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         if (cmd.emit_none) begin
            out_status_ff <= cmd.code;
            out_action_ff <= pfa_pkg::ACT_NONE;
            out_seg_ff    <= 1'b0;
            out_page_ff   <= '0;
            out_frame_ff  <= '0;
            out_last_ff   <= 1'b1;
         end else begin
            out_status_ff <= pfa_pkg::STAT_OK;
            out_action_ff <= cmd.map_step ? pfa_pkg::ACT_MAP : pfa_pkg::ACT_FREE;
            out_seg_ff    <= seg_ff;
            out_page_ff   <= pfa_pkg::IDX_OUT_W'(idx_ff);
            out_frame_ff  <= pfa_pkg::IDX_OUT_W'(cmd.map_step ? head_frame : rd_ff);
            out_last_ff   <= sts.last_item;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_frame_ff, out_page_ff, out_seg_ff, out_status_ff};
   assign rsp_tuser  = out_action_ff;
   assign rsp_tlast  = out_last_ff;

   // Status to the sequencer
   always_comb begin
      sts            = '0;
      sts.arrive     = arrive_ff;
      sts.slot_ok    = slot_ok_ff;
      sts.slot_busy  = busy;
      sts.fits       = (req_sum <= pfa_pkg::SUM_W'(count_ff));
      sts.total_zero = (tcnt_in == '0) && (dcnt_in == '0);
      sts.last_item  = seg_ff ? seg_end : (seg_end && (dcnt_ff == '0));
      sts.out_free   = out_free;
   end

   // Checks
   `PFA_ASSERT_SAME(a_count_max, clock, reset, 1'b1, count_ff <= CW'(pfa_pkg::NUM_FRAMES), "free count above frame total")
   `PFA_ASSERT_SAME(a_pop_nonempty, clock, reset, cmd.map_step, count_ff != '0, "frame popped from empty ring")
   `PFA_ASSERT_SAME(a_emit_room, clock, reset, emit, out_free, "result emitted over a pending result")

endmodule

`default_nettype wire

[rtl/core/page_frame_allocator_top.sv]
// Page frame allocator: Usage
// Request channel (req_*): one transfer per arrive/terminate request for a
// process slot; req_tuser carries the kind (0 arrive, 1 terminate).
// Result channel (rsp_*): one transfer per page mapped or frame freed, or a
// single no-page transfer when the request touches no page; rsp_tlast marks
// the final transfer of a request.
// Timing: request accepted in idle, decoded the next cycle; a mapped page is
// emitted directly, a freed frame first needs a registered read of the frame
// map memory. Requests are not overlapped: the next request is taken as soon
// as the last result sits in the output register.
// Reset: all slots empty, free ring holds frames 0..7 in order, no clearing
// pass is needed. A stalled rsp_tready holds the current result and pauses
// the page walk; nothing is dropped.
// Depends on pfa_pkg, pfa_ctrl and pfa_datapath.
`timescale 1ns / 1ps
`default_nettype none

module page_frame_allocator_top (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire  [pfa_pkg::REQ_DATA_W-1:0] req_tdata,  // proc_id[2:0], text_size[18:3],
                                                      // data_size[34:19], zero pad
   input  wire  [0:0]                     req_tuser,  // req_type
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [pfa_pkg::RSP_DATA_W-1:0] rsp_tdata,  // status[1:0], segment[2],
                                                      // page_index[5:3], frame_index[8:6], pad
   output logic [1:0]                     rsp_tuser,  // action
   output logic                           rsp_tlast   // last
);

   pfa_pkg::pfa_cmd_type cmd;
   pfa_pkg::pfa_sts_type sts;

   // Sequencer
   pfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Tables, ring, map memory and result register
   pfa_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire

[tb/page_frame_allocator_top_test.sv]
// Self-checking testbench for page_frame_allocator_top: drives arrive/terminate
// requests, predicts every mapped or freed frame and checks the result stream.
// Depends on pfa_pkg and the page_frame_allocator_top RTL.
`timescale 1ns / 1ps

module page_frame_allocator_top_test;

   localparam int IDLE_LIMIT = 2000;  // cycles with no transfer on either side
   localparam int LONG_HOLD  = 300;   // receiver back-pressure stretch
   localparam int DRAIN_WAIT = 40;    // quiet cycles after the last result

   // One result transfer as the block should present it
   typedef struct packed {
      pfa_pkg::pfa_status_type status;
      pfa_pkg::pfa_action_type action;
      logic                    segment;
      logic [2:0]              page_index;
      logic [2:0]              frame_index;
      logic                    last;
   } frame_event_type;

   // Shadow of the allocator: free ring, slot table and frame maps
   class frame_ledger;
      logic [2:0]      free_ring [pfa_pkg::NUM_FRAMES];
      int unsigned     ring_head;
      int unsigned     free_total;
      bit              slot_live [pfa_pkg::NUM_SLOTS];
      int unsigned     text_pages [pfa_pkg::NUM_SLOTS];
      int unsigned     data_pages [pfa_pkg::NUM_SLOTS];
      logic [2:0]      text_frames [pfa_pkg::NUM_SLOTS][pfa_pkg::NUM_FRAMES];
      logic [2:0]      data_frames [pfa_pkg::NUM_SLOTS][pfa_pkg::NUM_FRAMES];
      frame_event_type page_events_due [$];
      int              failures;

      function new();
         for (int i = 0; i < pfa_pkg::NUM_FRAMES; i++) free_ring[i] = 3'(i);
         ring_head  = 0;
         free_total = pfa_pkg::NUM_FRAMES;
         for (int s = 0; s < pfa_pkg::NUM_SLOTS; s++) begin
            slot_live[s]  = 1'b0;
            text_pages[s] = 0;
            data_pages[s] = 0;
         end
         failures = 0;
      endfunction

      static function int unsigned pages_for(logic [15:0] size);
         return (int'(size) + (1 << pfa_pkg::PAGE_BYTES_LOG2) - 1)
                >> pfa_pkg::PAGE_BYTES_LOG2;
      endfunction

      function void queue_event(pfa_pkg::pfa_status_type status,
                                pfa_pkg::pfa_action_type action,
                                logic segment, int unsigned page,
                                logic [2:0] frame, bit last);
         frame_event_type ev;
         ev.status      = status;
         ev.action      = action;
         ev.segment     = segment;
         ev.page_index  = 3'(page);
         ev.frame_index = frame;
         ev.last        = last;
         page_events_due.push_back(ev);
      endfunction

      function logic [2:0] take_frame();
         logic [2:0] f;
         f = free_ring[ring_head];
         ring_head = (ring_head + 1) % pfa_pkg::NUM_FRAMES;
         free_total--;
         return f;
      endfunction

      function void return_frame(logic [2:0] f);
         if (free_total < pfa_pkg::NUM_FRAMES) begin
            free_ring[(ring_head + free_total) % pfa_pkg::NUM_FRAMES] = f;
            free_total++;
         end
      endfunction

      // Update the shadow for one accepted request and queue its results
      function void apply_request(pfa_pkg::pfa_req_type kind, logic [2:0] proc,
                                  logic [15:0] text_size, logic [15:0] data_size);
         int unsigned tp, dp, total, k;
         logic [2:0]  f;
         bit          in_range;
         in_range = proc < pfa_pkg::NUM_SLOTS;
         k = 0;
         if (kind == pfa_pkg::REQ_ARRIVE) begin
            if (!in_range || slot_live[proc]) begin
               queue_event(pfa_pkg::STAT_BUSY, pfa_pkg::ACT_NONE, 1'b0, 0, 3'd0, 1'b1);
               return;
            end
            tp = pages_for(text_size);
            dp = pages_for(data_size);
            total = tp + dp;
            if (total > free_total) begin
               queue_event(pfa_pkg::STAT_NO_FRAMES, pfa_pkg::ACT_NONE,
                           1'b0, 0, 3'd0, 1'b1);
               return;
            end
            slot_live[proc]  = 1'b1;
            text_pages[proc] = tp;
            data_pages[proc] = dp;
            if (total == 0) begin
               queue_event(pfa_pkg::STAT_OK, pfa_pkg::ACT_NONE, 1'b0, 0, 3'd0, 1'b1);
               return;
            end
            for (int unsigned i = 0; i < tp; i++) begin
               f = take_frame();
               text_frames[proc][i] = f;
               k++;
               queue_event(pfa_pkg::STAT_OK, pfa_pkg::ACT_MAP, 1'b0, i, f, k == total);
            end
            for (int unsigned i = 0; i < dp; i++) begin
               f = take_frame();
               data_frames[proc][i] = f;
               k++;
               queue_event(pfa_pkg::STAT_OK, pfa_pkg::ACT_MAP, 1'b1, i, f, k == total);
            end
         end else begin
            if (!in_range || !slot_live[proc]) begin
               queue_event(pfa_pkg::STAT_EMPTY, pfa_pkg::ACT_NONE, 1'b0, 0, 3'd0, 1'b1);
               return;
            end
            tp = (text_pages[proc] > pfa_pkg::NUM_FRAMES)
                 ? pfa_pkg::NUM_FRAMES : text_pages[proc];
            dp = (data_pages[proc] > pfa_pkg::NUM_FRAMES)
                 ? pfa_pkg::NUM_FRAMES : data_pages[proc];
            total = tp + dp;
            slot_live[proc]  = 1'b0;
            text_pages[proc] = 0;
            data_pages[proc] = 0;
            if (total == 0) begin
               queue_event(pfa_pkg::STAT_OK, pfa_pkg::ACT_NONE, 1'b0, 0, 3'd0, 1'b1);
               return;
            end
            for (int unsigned i = 0; i < tp; i++) begin
               f = text_frames[proc][i];
               return_frame(f);
               k++;
               queue_event(pfa_pkg::STAT_OK, pfa_pkg::ACT_FREE, 1'b0, i, f, k == total);
            end
            for (int unsigned i = 0; i < dp; i++) begin
               f = data_frames[proc][i];
               return_frame(f);
               k++;
               queue_event(pfa_pkg::STAT_OK, pfa_pkg::ACT_FREE, 1'b1, i, f, k == total);
            end
         end
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      // Compare one result transfer against the oldest prediction
      function void check_frame_event(logic [1:0] status, logic [1:0] action,
                                      logic segment, logic [2:0] page_index,
                                      logic [2:0] frame_index, logic last);
         frame_event_type ev;
         if (page_events_due.size() == 0) begin
            $error("result transfer with nothing predicted: status %0d action %0d",
                   status, action);
            failures++;
            return;
         end
         ev = page_events_due.pop_front();
         compare_field("status",      ev.status,      status);
         compare_field("action",      ev.action,      action);
         compare_field("segment",     ev.segment,     segment);
         compare_field("page_index",  ev.page_index,  page_index);
         compare_field("frame_index", ev.frame_index, frame_index);
         compare_field("last",        ev.last,        last);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   frame_ledger ledger;
   bit          steady = 1'b0;        // no idling on either side while set
   bit          long_hold_req = 1'b0; // asks the receiver for a long stall
   int          idle_cycles_seen = 0;

   page_frame_allocator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // Gap length: mostly none or short, now and then long
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Smallest-to-largest byte count that still rounds up to n pages
   function automatic logic [15:0] size_for_pages(int unsigned n);
      if (n == 0) return 16'd0;
      return 16'((n - 1) * (1 << pfa_pkg::PAGE_BYTES_LOG2)
                 + $urandom_range(1, 1 << pfa_pkg::PAGE_BYTES_LOG2));
   endfunction

   // Offer one request, wait for its transfer, then idle for a random gap
   task automatic send_request(pfa_pkg::pfa_req_type kind, logic [2:0] proc,
                               logic [15:0] text_size, logic [15:0] data_size);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, data_size, text_size, proc};
      do @(posedge clock); while (!req_tready);
      ledger.apply_request(kind, proc, text_size, data_size);
      gap = steady ? 0 : idle_cycles();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Result receiver: random stalls after transfers, one long hold on request
   initial begin : receiver
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) stall = steady ? 0 : idle_cycles();
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall = LONG_HOLD;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         ledger.check_frame_event(rsp_tdata[1:0], rsp_tuser, rsp_tdata[2],
                                  rsp_tdata[5:3], rsp_tdata[8:6], rsp_tlast);
   end

   // Watchdog on stretches without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles_seen <= 0;
      end else if (idle_cycles_seen + 1 >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles_seen <= idle_cycles_seen + 1;
      end
   end

   // Main sequence
   initial begin : stimulus
      pfa_pkg::pfa_req_type kind;
      logic [2:0]           proc;
      logic [15:0]          text_size, data_size;
      int unsigned          tp, dp;
      ledger = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty and out-of-range slots, zero-size process, refusals,
      // every segment mix and full occupancy of the ring
      send_request(pfa_pkg::REQ_TERM,   3'd0, 16'd0,     16'd0);
      send_request(pfa_pkg::REQ_ARRIVE, 3'd7, 16'd100,   16'd100);
      send_request(pfa_pkg::REQ_TERM,   3'd5, 16'd0,     16'd0);
      send_request(pfa_pkg::REQ_ARRIVE, 3'd0, 16'd0,     16'd0);
      send_request(pfa_pkg::REQ_ARRIVE, 3'd0, 16'd512,   16'd1);
      send_request(pfa_pkg::REQ_TERM,   3'd0, 16'd0,     16'd0);
      send_request(pfa_pkg::REQ_ARRIVE, 3'd1, 16'hFFFF,  16'hFFFF);
      send_request(pfa_pkg::REQ_ARRIVE, 3'd1, 16'd1,     16'd512);
      send_request(pfa_pkg::REQ_ARRIVE, 3'd2, 16'd513,   16'd0);
      send_request(pfa_pkg::REQ_ARRIVE, 3'd3, 16'd0,     16'd2048);
      send_request(pfa_pkg::REQ_ARRIVE, 3'd4, 16'd1,     16'd0);
      send_request(pfa_pkg::REQ_TERM,   3'd2, 16'd0,     16'd0);
      send_request(pfa_pkg::REQ_TERM,   3'd1, 16'd0,     16'd0);
      send_request(pfa_pkg::REQ_ARRIVE, 3'd4, 16'd1024,  16'd512);
      send_request(pfa_pkg::REQ_TERM,   3'd3, 16'd0,     16'd0);
      send_request(pfa_pkg::REQ_TERM,   3'd4, 16'd0,     16'd0);
      send_request(pfa_pkg::REQ_ARRIVE, 3'd0, 16'd2048,  16'd2048);
      send_request(pfa_pkg::REQ_TERM,   3'd0, 16'hFFFF,  16'hFFFF);
      send_request(pfa_pkg::REQ_ARRIVE, 3'd1, 16'd4096,  16'd0);
      send_request(pfa_pkg::REQ_TERM,   3'd1, 16'd0,     16'd0);
      send_request(pfa_pkg::REQ_ARRIVE, 3'd2, 16'd0,     16'd4096);
      send_request(pfa_pkg::REQ_TERM,   3'd2, 16'd0,     16'd0);
      send_request(pfa_pkg::REQ_ARRIVE, 3'd6, 16'hFFFF,  16'hFFFF);
      send_request(pfa_pkg::REQ_TERM,   3'd7, 16'd0,     16'd0);
      send_request(pfa_pkg::REQ_ARRIVE, 3'd3, 16'd0,     16'd4097);

      // Random: mostly well-formed lifecycles on valid slots, some noise
      for (int n = 0; n < 190; n++) begin
         steady = (n >= 40 && n < 80);
         if (n == 120) long_hold_req = 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            kind      = pfa_pkg::pfa_req_type'($urandom_range(0, 1));
            proc      = 3'($urandom_range(0, 7));
            text_size = 16'($urandom);
            data_size = 16'($urandom);
         end else begin
            proc = 3'($urandom_range(0, pfa_pkg::NUM_SLOTS - 1));
            if (ledger.slot_live[proc])
               kind = ($urandom_range(0, 9) == 0) ? pfa_pkg::REQ_ARRIVE : pfa_pkg::REQ_TERM;
            else
               kind = ($urandom_range(0, 9) == 0) ? pfa_pkg::REQ_TERM : pfa_pkg::REQ_ARRIVE;
            tp = $urandom_range(0, ledger.free_total);
            dp = $urandom_range(0, ledger.free_total - tp);
            text_size = size_for_pages(tp);
            data_size = size_for_pages(dp);
         end
         send_request(kind, proc, text_size, data_size);
      end
      steady = 1'b0;

      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain outstanding results, then watch for strays
      while (ledger.page_events_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (ledger.failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
